@@ hw/rtl/sdos_pkg.sv @@
// Shared types and constants for the shortest diagonal orientation select pipeline.
package sdos_pkg;

    // Component width is fixed by the word format (signed Q7.16).
    localparam int COMP_W    = 24;
    // A diagonal component is the sum of three components.
    localparam int SUM_W     = COMP_W + 2;
    // Its magnitude never exceeds three times two to the power COMP_W - 1.
    localparam int MAG_W     = COMP_W + 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int LEN_W     = SQ_W + 1;
    localparam int OUT_LEN_W = 51;

    // Only the four sign patterns that keep row 0 positive can win.
    localparam int NUM_CAND  = 4;
    localparam int CAND_W    = 2;

    localparam logic [1:0] PERM_TABLE [0:5][0:2] = '{
        '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
        '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}
    };

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic [SQ_W-1:0]          t_sq;
    typedef logic [LEN_W-1:0]         t_len;
    typedef logic [CAND_W-1:0]        t_cand;

    typedef struct packed {
        t_comp row0_x;
        t_comp row0_y;
        t_comp row0_z;
        t_comp row1_x;
        t_comp row1_y;
        t_comp row1_z;
        t_comp row2_x;
        t_comp row2_y;
        t_comp row2_z;
    } t_sdos_in;

    typedef struct packed {
        logic [1:0]           order_0;
        logic [1:0]           order_1;
        logic [1:0]           order_2;
        logic                 negate_0;
        logic                 negate_1;
        logic                 negate_2;
        logic [OUT_LEN_W-1:0] best_length_sq;
    } t_sdos_out;

endpackage

@@ hw/rtl/sdos_diag.sv @@
// Diagonal component sums and their magnitudes, two register stages.
module sdos_diag (
    input  logic               i_clk,
    input  logic [1:0]         i_en,
    input  sdos_pkg::t_sdos_in i_in,
    output sdos_pkg::t_mag     o_mag [sdos_pkg::NUM_CAND][3]
);
    import sdos_pkg::*;

    t_comp w_row [3][3];
    t_sum  n_d   [NUM_CAND][3];
    t_sum  r_d   [NUM_CAND][3];
    t_mag  n_mag [NUM_CAND][3];
    t_mag  r_mag [NUM_CAND][3];

    assign w_row[0][0] = i_in.row0_x;
    assign w_row[0][1] = i_in.row0_y;
    assign w_row[0][2] = i_in.row0_z;
    assign w_row[1][0] = i_in.row1_x;
    assign w_row[1][1] = i_in.row1_y;
    assign w_row[1][2] = i_in.row1_z;
    assign w_row[2][0] = i_in.row2_x;
    assign w_row[2][1] = i_in.row2_y;
    assign w_row[2][2] = i_in.row2_z;

    // Candidate s: row 0 enters negated, row 1 negated when s[1] is set,
    // row 2 added when s[0] is set and subtracted otherwise.
    always_comb begin
        t_cand sel;
        t_sum  acc;
        for (int s = 0; s < NUM_CAND; s++) begin
            sel = CAND_W'(s);
            for (int c = 0; c < 3; c++) begin
                acc = -SUM_W'(w_row[0][c]);
                acc = sel[1] ? acc - SUM_W'(w_row[1][c]) : acc + SUM_W'(w_row[1][c]);
                acc = sel[0] ? acc + SUM_W'(w_row[2][c]) : acc - SUM_W'(w_row[2][c]);
                n_d[s][c] = acc;
            end
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_CAND; s++) begin
            for (int c = 0; c < 3; c++) begin
                n_mag[s][c] = r_d[s][c][SUM_W-1] ? MAG_W'(-r_d[s][c]) : MAG_W'(r_d[s][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d <= n_d;
        end
        if (i_en[1]) begin
            r_mag <= n_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

@@ hw/rtl/sdos_square.sv @@
// Component squares and squared diagonal lengths, two register stages.
module sdos_square (
    input  logic           i_clk,
    input  logic [1:0]     i_en,
    input  sdos_pkg::t_mag i_mag [sdos_pkg::NUM_CAND][3],
    output sdos_pkg::t_len o_len [sdos_pkg::NUM_CAND]
);
    import sdos_pkg::*;

    t_sq  n_sq  [NUM_CAND][3];
    t_sq  r_sq  [NUM_CAND][3];
    t_len n_len [NUM_CAND];
    t_len r_len [NUM_CAND];

    always_comb begin
        for (int s = 0; s < NUM_CAND; s++) begin
            for (int c = 0; c < 3; c++) begin
                n_sq[s][c] = SQ_W'(i_mag[s][c]) * SQ_W'(i_mag[s][c]);
            end
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_CAND; s++) begin
            n_len[s] = LEN_W'(r_sq[s][0]) + LEN_W'(r_sq[s][1]) + LEN_W'(r_sq[s][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sq <= n_sq;
        end
        if (i_en[1]) begin
            r_len <= n_len;
        end
    end

    assign o_len = r_len;

endmodule

@@ hw/rtl/sdos_select.sv @@
// First-minimum selection over the candidate lengths, two register stages.
module sdos_select (
    input  logic                i_clk,
    input  logic [1:0]          i_en,
    input  sdos_pkg::t_len      i_len [sdos_pkg::NUM_CAND],
    output sdos_pkg::t_sdos_out o_out
);
    import sdos_pkg::*;

    t_len      n_pair_len [2];
    t_cand     n_pair_sel [2];
    t_len      r_pair_len [2];
    t_cand     r_pair_sel [2];
    t_sdos_out n_out;
    t_sdos_out r_out;

    // A later candidate replaces an earlier one only when strictly shorter.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (i_len[2*k+1] < i_len[2*k]) begin
                n_pair_len[k] = i_len[2*k+1];
                n_pair_sel[k] = CAND_W'(2*k+1);
            end else begin
                n_pair_len[k] = i_len[2*k];
                n_pair_sel[k] = CAND_W'(2*k);
            end
        end
    end

    always_comb begin
        t_len  best_len;
        t_cand best_sel;
        if (r_pair_len[1] < r_pair_len[0]) begin
            best_len = r_pair_len[1];
            best_sel = r_pair_sel[1];
        end else begin
            best_len = r_pair_len[0];
            best_sel = r_pair_sel[0];
        end
        n_out.order_0        = PERM_TABLE[0][0];
        n_out.order_1        = PERM_TABLE[0][1];
        n_out.order_2        = PERM_TABLE[0][2];
        n_out.negate_0       = 1'b0;
        n_out.negate_1       = best_sel[1];
        n_out.negate_2       = best_sel[0];
        n_out.best_length_sq = OUT_LEN_W'(best_len);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pair_len <= n_pair_len;
            r_pair_sel <= n_pair_sel;
        end
        if (i_en[1]) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

@@ hw/rtl/shortest_diagonal_orientation_select.sv @@
// Top level of the shortest diagonal orientation select pipeline.
//
// The block takes one 3x3 matrix word of signed Q7.16 rows and returns one
// result word: the row order, the row negation flags and the smallest squared
// length, in unsigned Q19.32, of the diagonal -T0 + T1 - T2 over all six row
// orders and eight sign patterns, the first minimum in search order winning a
// tie. Reordering the rows only renames which rows are negated, so the
// identity order already reaches every sign combination and, being searched
// first, always holds the first minimum; the order fields are therefore the
// identity. Negating all three rows leaves the length unchanged, so only the
// four patterns with row 0 positive are candidates. The datapath is a
// six-stage pipeline: component sums, magnitudes, squares, length sums, a
// pairwise compare and the final compare into the output register. It takes
// a new word every cycle as long as the output side is not stalled. Every
// stage has its own valid bit and advances when it is empty or its successor
// advances, so empty stages fill up while a finished result waits at the
// output.
module shortest_diagonal_orientation_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sdos_pkg::t_sdos_in  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output sdos_pkg::t_sdos_out o_out
);
    import sdos_pkg::*;

    localparam int NUM_STAGES = 6;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] w_en;
    t_mag                  w_mag [NUM_CAND][3];
    t_len                  w_len [NUM_CAND];

    // A stage loads when it is empty or its successor moves on.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_valid[0] = w_en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = w_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_valid[NUM_STAGES-1];

    sdos_diag u_diag (
        .i_clk (i_clk),
        .i_en  (w_en[1:0]),
        .i_in  (i_in),
        .o_mag (w_mag)
    );

    sdos_square u_square (
        .i_clk (i_clk),
        .i_en  (w_en[3:2]),
        .i_mag (w_mag),
        .o_len (w_len)
    );

    sdos_select u_select (
        .i_clk (i_clk),
        .i_en  (w_en[5:4]),
        .i_len (w_len),
        .o_out (o_out)
    );

    // The input side is held off only when every stage is full and the
    // output word is stalled.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_valid && i_stall))
        else $error("input stalled while the pipeline has room");

    // A word in the pairwise compare stage reaches the output when not blocked.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NUM_STAGES-2] && !(o_valid && i_stall)) |=> o_valid)
        else $error("word lost between the compare stages and the output");

    // Row 0 is never negated in a winning candidate.
    a_row0_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.negate_0 == 1'b0))
        else $error("row 0 negated in the result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0))
        else $error("pipeline not empty after reset");

endmodule
